[hw/rtl/exposure_and_diode_edge_detector_macros.svh]
// ---------------------------------------------------------------------------
// exposure and diode edge detector assertion macros
// concurrent check helpers, empty when synthesized
// ---------------------------------------------------------------------------
`ifndef EXPOSURE_AND_DIODE_EDGE_DETECTOR_MACROS_SVH
`define EXPOSURE_AND_DIODE_EDGE_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, off during reset
`define EDED_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("eded check failed");
// next-cycle implication, off during reset
`define EDED_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("eded check failed");
`else
`define EDED_ASSERT_SAME(label, clk, rstn, ante, cons)
`define EDED_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

[hw/rtl/eded_pkg.sv]
// ---------------------------------------------------------------------------
// eded_pkg
// shared widths, reset values, register map and types of the edge detector
// ---------------------------------------------------------------------------
`default_nettype none

package eded_pkg;

    // sample and timestamp widths
    localparam int SAMPLE_BITS = 16;
    localparam int TIME_BITS   = 32;

    // result field widths
    localparam int OUT_TIME_W = 32;
    localparam int HEIGHT_W   = 16;

    // register widths
    localparam int LEVEL_W = 15;
    localparam int STEP_W  = 16;
    localparam int MINH_W  = 16;

    // compare width: holds a sample difference and any threshold
    localparam int CMP_W = (SAMPLE_BITS + 2 > STEP_W + 2) ? SAMPLE_BITS + 2 : STEP_W + 2;

    // apb port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_CAMERA_LEVEL = 2'd0;
    localparam logic [1:0] REG_RISE_STEP    = 2'd1;
    localparam logic [1:0] REG_MIN_HEIGHT   = 2'd2;

    // register reset values
    localparam logic [LEVEL_W-1:0] CAMERA_LEVEL_RST = LEVEL_W'(14746);
    localparam logic [STEP_W-1:0]  RISE_STEP_RST    = STEP_W'(16);
    localparam logic [MINH_W-1:0]  MIN_HEIGHT_RST   = MINH_W'(164);

    // largest positive sample code
    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    // largest reported height
    localparam logic signed [CMP_W-1:0] HEIGHT_MAX =
        signed'({{(CMP_W-HEIGHT_W){1'b0}}, {HEIGHT_W{1'b1}}});

    typedef struct packed {
        logic [LEVEL_W-1:0] camera_level;
        logic [STEP_W-1:0]  rise_step;
        logic [MINH_W-1:0]  min_height;
    } cfg_t;

    typedef struct packed {
        logic                  pulse;
        logic [OUT_TIME_W-1:0] start_time;
        logic [HEIGHT_W-1:0]   height;
    } diode_result_t;

    // sign-extend a sample to compare width
    function automatic logic signed [CMP_W-1:0] sext_sample(input logic [SAMPLE_BITS-1:0] s);
        return signed'({{(CMP_W-SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s});
    endfunction

    // zero-extend a 16-bit threshold to compare width
    function automatic logic signed [CMP_W-1:0] zext_thr(input logic [STEP_W-1:0] v);
        return signed'({{(CMP_W-STEP_W){1'b0}}, v});
    endfunction

    // low bits of a timestamp, zero-extended when narrower
    function automatic logic [OUT_TIME_W-1:0] out_time(input logic [TIME_BITS-1:0] t);
        logic [TIME_BITS+OUT_TIME_W-1:0] wide;
        wide = {{OUT_TIME_W{1'b0}}, t};
        return wide[OUT_TIME_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/eded_regs.sv]
// ---------------------------------------------------------------------------
// eded_regs
// apb configuration registers: camera level, rise step, minimum height
// ---------------------------------------------------------------------------
`default_nettype none

module eded_regs (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [eded_pkg::ADDR_W-1:0] paddr,
    input  wire logic [eded_pkg::DATA_W-1:0] pwdata,
    output logic      [eded_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output eded_pkg::cfg_t                  cfg
);
    import eded_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_CAMERA_LEVEL: cfg_next.camera_level = pwdata[LEVEL_W-1:0];
                REG_RISE_STEP:    cfg_next.rise_step    = pwdata[STEP_W-1:0];
                REG_MIN_HEIGHT:   cfg_next.min_height   = pwdata[MINH_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.camera_level <= CAMERA_LEVEL_RST;
            cfg_reg.rise_step    <= RISE_STEP_RST;
            cfg_reg.min_height   <= MIN_HEIGHT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            REG_CAMERA_LEVEL: prdata = {{(DATA_W-LEVEL_W){1'b0}}, cfg_reg.camera_level};
            REG_RISE_STEP:    prdata = {{(DATA_W-STEP_W){1'b0}}, cfg_reg.rise_step};
            REG_MIN_HEIGHT:   prdata = {{(DATA_W-MINH_W){1'b0}}, cfg_reg.min_height};
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/eded_camera.sv]
// ---------------------------------------------------------------------------
// eded_camera
// exposure channel: edge on rise above the level, re-arm below it
// ---------------------------------------------------------------------------
`default_nettype none

module eded_camera (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            step,
    input  wire logic [eded_pkg::SAMPLE_BITS-1:0] camera_sample,
    input  wire eded_pkg::cfg_t                  cfg,
    output logic                                 camera_edge
);
    import eded_pkg::*;

    logic                    high_reg;
    logic                    high_next;
    logic signed [CMP_W-1:0] cam;
    logic signed [CMP_W-1:0] lvl;

    assign cam = sext_sample(camera_sample);
    assign lvl = zext_thr({{(STEP_W-LEVEL_W){1'b0}}, cfg.camera_level});

    // level compare with hysteresis-free re-arm, equal level holds state
    always_comb begin
        high_next   = high_reg;
        camera_edge = 1'b0;
        if (cam < lvl && high_reg) begin
            high_next = 1'b0;
        end else if (cam > lvl && !high_reg) begin
            high_next   = 1'b1;
            camera_edge = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_reg <= 1'b0;
        end else if (step) begin
            high_reg <= high_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/eded_diode.sv]
// ---------------------------------------------------------------------------
// eded_diode
// photodiode channel: slope-triggered rise tracking and pulse report
// ---------------------------------------------------------------------------
`default_nettype none

module eded_diode (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            step,
    input  wire logic [eded_pkg::SAMPLE_BITS-1:0] diode_sample,
    input  wire logic [eded_pkg::TIME_BITS-1:0]   sample_count,
    input  wire eded_pkg::cfg_t                  cfg,
    output eded_pkg::diode_result_t              result
);
    import eded_pkg::*;

    logic                   rising_reg;
    logic                   rising_next;
    logic [SAMPLE_BITS-1:0] last_reg;
    logic [SAMPLE_BITS-1:0] baseline_reg;
    logic [SAMPLE_BITS-1:0] baseline_next;
    logic [TIME_BITS-1:0]   start_reg;
    logic [TIME_BITS-1:0]   start_next;

    logic signed [CMP_W-1:0] diff;
    logic signed [CMP_W-1:0] height;
    logic                    step_up;
    logic                    tall;
    logic                    sat;

    // slope and height arithmetic
    assign diff    = sext_sample(diode_sample) - sext_sample(last_reg);
    assign height  = sext_sample(last_reg) - sext_sample(baseline_reg);
    assign step_up = diff > zext_thr(cfg.rise_step);
    assign tall    = height > zext_thr(cfg.min_height);
    assign sat     = height > HEIGHT_MAX;

    // rise tracking and pulse report
    always_comb begin
        rising_next   = rising_reg;
        baseline_next = baseline_reg;
        start_next    = start_reg;
        result        = '0;
        if (step_up) begin
            if (!rising_reg) begin
                rising_next   = 1'b1;
                start_next    = sample_count;
                baseline_next = last_reg;
            end
        end else if (rising_reg) begin
            rising_next = 1'b0;
            if (tall) begin
                result.pulse      = 1'b1;
                result.start_time = out_time(start_reg);
                result.height     = sat ? {HEIGHT_W{1'b1}} : height[HEIGHT_W-1:0];
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rising_reg <= 1'b0;
            last_reg   <= FULL_SCALE;
        end else if (step) begin
            rising_reg <= rising_next;
            last_reg   <= diode_sample;
        end
    end

    // rise payload, written on rise start
    always_ff @(posedge aclk) begin
        if (step) begin
            baseline_reg <= baseline_next;
            start_reg    <= start_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/exposure_and_diode_edge_detector.sv]
// ---------------------------------------------------------------------------
// exposure_and_diode_edge_detector
// camera exposure edge and photodiode pulse detector on a two-channel scan
// ---------------------------------------------------------------------------
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  scan in | s_valid/s_ready, s_*_sample    | in
//  result  | m_valid/m_ready, m_* fields    | out
//  config  | apb psel/penable/pwrite/paddr  | in
//
//  one item per cycle while m_ready stays high; m_valid rises once an accepted item
//  moves from the input register into the result register, where it can be taken
//  the item sits in an input register, channel logic runs between it and the
//  result register, and channel state updates as the item moves into that register
//  a stalled result holds the input register; s_ready stays high while it is empty
//  reset is synchronous active low; no clearing pass
// ---------------------------------------------------------------------------
`default_nettype none

`include "exposure_and_diode_edge_detector_macros.svh"

module exposure_and_diode_edge_detector (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // scan input
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [eded_pkg::SAMPLE_BITS-1:0] s_diode_sample,
    input  wire logic [eded_pkg::SAMPLE_BITS-1:0] s_camera_sample,
    // result output
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_camera_edge,
    output logic      [eded_pkg::OUT_TIME_W-1:0]  m_camera_time,
    output logic                                  m_diode_pulse,
    output logic      [eded_pkg::OUT_TIME_W-1:0]  m_diode_start_time,
    output logic      [eded_pkg::HEIGHT_W-1:0]    m_diode_height,
    // configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [eded_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [eded_pkg::DATA_W-1:0]      pwdata,
    output logic      [eded_pkg::DATA_W-1:0]      prdata,
    output logic                                  pready
);
    import eded_pkg::*;

    cfg_t cfg;

    // input register
    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] diode_in_reg;
    logic [SAMPLE_BITS-1:0] camera_in_reg;

    // result register
    logic                  out_valid_reg;
    logic                  cam_edge_reg;
    logic [OUT_TIME_W-1:0] cam_time_reg;
    diode_result_t         diode_res_reg;

    logic [TIME_BITS-1:0] sample_count_reg;
    logic                 advance;
    logic                 cam_edge;
    diode_result_t        diode_res;

    // handshake
    assign advance = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready = ~in_valid_reg | advance;

    eded_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    eded_camera u_camera (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .camera_sample (camera_in_reg),
        .cfg           (cfg),
        .camera_edge   (cam_edge)
    );

    eded_diode u_diode (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .diode_sample (diode_in_reg),
        .sample_count (sample_count_reg),
        .cfg          (cfg),
        .result       (diode_res)
    );

    // input stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // input stage payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            diode_in_reg  <= s_diode_sample;
            camera_in_reg <= s_camera_sample;
        end
    end

    // timestamp counter, wraps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= '0;
        end else if (advance) begin
            sample_count_reg <= sample_count_reg + TIME_BITS'(1);
        end
    end

    // result stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result stage payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            cam_edge_reg  <= cam_edge;
            cam_time_reg  <= cam_edge ? out_time(sample_count_reg) : '0;
            diode_res_reg <= diode_res;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_camera_edge      = cam_edge_reg;
    assign m_camera_time      = cam_time_reg;
    assign m_diode_pulse      = diode_res_reg.pulse;
    assign m_diode_start_time = diode_res_reg.start_time;
    assign m_diode_height     = diode_res_reg.height;

    // checks
    `EDED_ASSERT_SAME(a_cam_time_zero, aclk, aresetn, m_valid && !m_camera_edge, m_camera_time == '0)
    `EDED_ASSERT_SAME(a_pulse_zero, aclk, aresetn, m_valid && !m_diode_pulse, m_diode_start_time == '0 && m_diode_height == '0)
    `EDED_ASSERT_SAME(a_pulse_tall, aclk, aresetn, m_valid && m_diode_pulse, m_diode_height > cfg.min_height)
    `EDED_ASSERT_NEXT(a_item_held, aclk, aresetn, in_valid_reg && !advance, in_valid_reg)

endmodule

`default_nettype wire

[bench/tb_exposure_and_diode_edge_detector.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_exposure_and_diode_edge_detector
// Feeds two-channel scans through the edge detector under several register
// settings and flow-control patterns. A behavioral copy of both channels
// predicts each unpinned result, and each result is compared field by field.
// ----------------------------------------------------------------------------

module tb_exposure_and_diode_edge_detector;

    import eded_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES = 4;

    // spare register slot, writes there must be ignored
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic                  camera_edge;
        logic [OUT_TIME_W-1:0] camera_time;
        diode_result_t         diode;
    } scan_result_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] diode;
        logic [SAMPLE_BITS-1:0] camera;
        logic                   pinned;
        scan_result_t           want;
    } scan_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [SAMPLE_BITS-1:0] s_diode_sample = '0;
    logic [SAMPLE_BITS-1:0] s_camera_sample = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_camera_edge;
    logic [OUT_TIME_W-1:0]  m_camera_time;
    logic                   m_diode_pulse;
    logic [OUT_TIME_W-1:0]  m_diode_start_time;
    logic [HEIGHT_W-1:0]    m_diode_height;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ADDR_W-1:0]      paddr = '0;
    logic [DATA_W-1:0]      pwdata = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    exposure_and_diode_edge_detector dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_diode_sample     (s_diode_sample),
        .s_camera_sample    (s_camera_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_camera_edge      (m_camera_edge),
        .m_camera_time      (m_camera_time),
        .m_diode_pulse      (m_diode_pulse),
        .m_diode_start_time (m_diode_start_time),
        .m_diode_height     (m_diode_height),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // shadow registers and channel state
    logic [LEVEL_W-1:0]     camera_level_q;
    logic [STEP_W-1:0]      rise_step_q;
    logic [MINH_W-1:0]      min_height_q;
    logic                   camera_high;
    logic                   diode_rising;
    logic signed [17:0]     last_level;
    logic signed [17:0]     rise_baseline;
    logic [TIME_BITS-1:0]   rise_start;
    logic [TIME_BITS-1:0]   sample_count;

    scan_result_t scan_results_due[$];
    scan_row_t    directed_scans[$];
    idle_mode_t   idle_mode = IDLE_NONE;
    int           mismatches = 0;
    int           scans_sent = 0;
    int           camera_edges_seen = 0;
    int           pulses_seen = 0;
    int           reg_writes = 0;
    int           holds_requested = 0;
    int           wave_level = 0;
    int           ramp_left = 0;

    // clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // run limit
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb_exposure_and_diode_edge_detector NOT OK");
        $finish;
    end

    function automatic void reset_tracker();
        camera_level_q = CAMERA_LEVEL_RST;
        rise_step_q    = RISE_STEP_RST;
        min_height_q   = MIN_HEIGHT_RST;
        camera_high    = 1'b0;
        diode_rising   = 1'b0;
        last_level     = 18'sd32767;
        rise_baseline  = '0;
        rise_start     = '0;
        sample_count   = '0;
    endfunction

    // camera level crossing and diode rise tracking for one scan
    function automatic scan_result_t track_scan(input logic [SAMPLE_BITS-1:0] diode,
                                                input logic [SAMPLE_BITS-1:0] camera);
        scan_result_t       r;
        logic signed [17:0] cam_x;
        logic signed [17:0] diode_x;
        logic signed [17:0] step_x;
        logic signed [17:0] height_x;
        r = '0;
        cam_x   = $signed(camera);
        diode_x = $signed(diode);
        // camera arms on a rise above the level, re-arms below it
        if (cam_x < $signed({3'b000, camera_level_q}) && camera_high) begin
            camera_high = 1'b0;
        end else if (cam_x > $signed({3'b000, camera_level_q}) && !camera_high) begin
            camera_high   = 1'b1;
            r.camera_edge = 1'b1;
            r.camera_time = sample_count[OUT_TIME_W-1:0];
            camera_edges_seen++;
        end
        // diode rise starts on a steep step, reports on the first flat one
        step_x = diode_x - last_level;
        if (step_x > $signed({2'b00, rise_step_q})) begin
            if (!diode_rising) begin
                diode_rising  = 1'b1;
                rise_start    = sample_count;
                rise_baseline = last_level;
            end
        end else if (diode_rising) begin
            diode_rising = 1'b0;
            height_x = last_level - rise_baseline;
            if (height_x > $signed({2'b00, min_height_q})) begin
                r.diode.pulse      = 1'b1;
                r.diode.start_time = rise_start[OUT_TIME_W-1:0];
                r.diode.height     = (height_x > 18'sd65535) ? '1 : height_x[HEIGHT_W-1:0];
                pulses_seen++;
            end
        end
        last_level   = diode_x;
        sample_count = sample_count + TIME_BITS'(1);
        return r;
    endfunction

    function automatic int clamp_code(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic scan_row_t free_row(input logic [SAMPLE_BITS-1:0] diode,
                                           input logic [SAMPLE_BITS-1:0] camera);
        scan_row_t r;
        r = '0;
        r.diode  = diode;
        r.camera = camera;
        return r;
    endfunction

    function automatic scan_row_t pinned_row(input logic [SAMPLE_BITS-1:0] diode,
                                             input logic [SAMPLE_BITS-1:0] camera,
                                             input logic cam_edge,
                                             input logic [OUT_TIME_W-1:0] cam_time,
                                             input logic pulse,
                                             input logic [OUT_TIME_W-1:0] start,
                                             input logic [HEIGHT_W-1:0] height);
        scan_row_t r;
        r = free_row(diode, camera);
        r.pinned                = 1'b1;
        r.want.camera_edge      = cam_edge;
        r.want.camera_time      = cam_time;
        r.want.diode.pulse      = pulse;
        r.want.diode.start_time = start;
        r.want.diode.height     = height;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // result side: check each accepted item, then pick next ready
    initial begin
        scan_result_t want;
        int           hold_left;
        int           holds_done;
        hold_left  = 0;
        holds_done = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid === 1'b1 && m_ready) begin
                if (scan_results_due.size() == 0) begin
                    $error("result item arrived with nothing outstanding");
                    mismatches++;
                end else begin
                    want = scan_results_due.pop_front();
                    check_field("camera_edge", 32'(want.camera_edge), 32'(m_camera_edge));
                    check_field("camera_time", want.camera_time, m_camera_time);
                    check_field("diode_pulse", 32'(want.diode.pulse), 32'(m_diode_pulse));
                    check_field("diode_start_time", want.diode.start_time,
                                m_diode_start_time);
                    check_field("diode_height", 32'(want.diode.height),
                                32'(m_diode_height));
                end
            end
            // long hold-off on request, else random stalls by mode
            if (holds_done != holds_requested) begin
                holds_done = holds_requested;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (idle_mode)
                    IDLE_RECEIVER: m_ready <= ($urandom_range(0, 99) >= 83);
                    IDLE_BOTH:     m_ready <= ($urandom_range(0, 99) >= 8);
                    default:       m_ready <= 1'b1;
                endcase
            end
        end
    end

    // offer one scan, wait for acceptance, record its prediction
    task automatic send_scan(input logic [SAMPLE_BITS-1:0] diode,
                             input logic [SAMPLE_BITS-1:0] camera,
                             input logic pinned, input scan_result_t want);
        scan_result_t predicted;
        int           idle_pct;
        case (idle_mode)
            IDLE_SENDER: idle_pct = 83;
            IDLE_BOTH:   idle_pct = 8;
            default:     idle_pct = 0;
        endcase
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_diode_sample  <= diode;
        s_camera_sample <= camera;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predicted = track_scan(diode, camera);
        scan_results_due.push_back(pinned ? want : predicted);
        scans_sent++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        s_valid <= 1'b0;
        while (scan_results_due.size() != 0) @(posedge aclk);
    endtask

    // apb write, setup then access phase
    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] data);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CAMERA_LEVEL: camera_level_q = data[LEVEL_W-1:0];
            REG_RISE_STEP:    rise_step_q = data[STEP_W-1:0];
            REG_MIN_HEIGHT:   min_height_q = data[MINH_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic write_settings(input logic [LEVEL_W-1:0] level,
                                  input logic [STEP_W-1:0] step,
                                  input logic [MINH_W-1:0] minh);
        // junk above each register's width must be dropped
        write_reg(REG_CAMERA_LEVEL, {17'($urandom), level});
        write_reg(REG_RISE_STEP, {16'($urandom), step});
        write_reg(REG_MIN_HEIGHT, {16'($urandom), minh});
    endtask

    // mostly ramps and level crossings, some full-range noise
    task automatic next_random_scan(output logic [SAMPLE_BITS-1:0] diode,
                                    output logic [SAMPLE_BITS-1:0] camera);
        int pick;
        int step_i;
        int level_i;
        int delta;
        step_i  = int'(rise_step_q);
        level_i = int'(camera_level_q);
        pick    = $urandom_range(0, 99);
        if (pick < 20) begin
            diode      = SAMPLE_BITS'($urandom);
            wave_level = int'($signed(diode));
        end else begin
            if (ramp_left == 0 && pick < 40) ramp_left = $urandom_range(1, 8);
            if (ramp_left > 0) begin
                delta = step_i + 1 + int'($urandom_range(0, 40));
                ramp_left--;
            end else if (pick < 50) begin
                delta = step_i;
            end else if (pick < 60) begin
                delta = step_i + 1;
            end else if (pick < 75) begin
                delta = 0 - int'($urandom_range(0, 3000));
            end else begin
                delta = int'($urandom_range(0, 2 * step_i + 2)) - step_i - 1;
            end
            wave_level = clamp_code(wave_level + delta);
            diode      = SAMPLE_BITS'(wave_level);
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            camera = SAMPLE_BITS'(clamp_code(level_i + int'($urandom_range(0, 6)) - 3));
        end else begin
            camera = SAMPLE_BITS'($urandom);
        end
    endtask

    task automatic run_phase(input idle_mode_t mode, input int count, input bit pressure);
        logic [SAMPLE_BITS-1:0] diode;
        logic [SAMPLE_BITS-1:0] camera;
        idle_mode = mode;
        // receiver holds off while items keep coming
        if (pressure) holds_requested++;
        for (int i = 0; i < count; i++) begin
            if (pressure && i == count / 2) drain_results();
            next_random_scan(diode, camera);
            send_scan(diode, camera, 1'b0, '0);
        end
        drain_results();
    endtask

    // stimulus
    initial begin
        reset_tracker();
        // after reset, full-scale extremes
        directed_scans.push_back(pinned_row(16'd0, 16'd0, 1'b0, 0, 1'b0, 0, 16'd0));
        directed_scans.push_back(pinned_row(16'h8000, 16'h8000, 1'b0, 0, 1'b0, 0, 16'd0));
        directed_scans.push_back(pinned_row(16'h7FFF, 16'h7FFF, 1'b1, 2, 1'b0, 0, 16'd0));
        directed_scans.push_back(pinned_row(16'h7FFF, 16'h7FFF, 1'b0, 0, 1'b1, 2, 16'hFFFF));
        // camera at the level, just below, at the level again, just above
        directed_scans.push_back(free_row(16'd0, 16'd14746));
        directed_scans.push_back(free_row(16'd16, 16'd14745));
        directed_scans.push_back(free_row(16'd33, 16'd14746));
        directed_scans.push_back(free_row(16'd197, 16'd14747));
        directed_scans.push_back(free_row(16'd197, 16'd14747));
        // height equal to minimum is dropped
        directed_scans.push_back(free_row(16'd214, 16'hFFFF));
        directed_scans.push_back(free_row(16'd361, 16'h7FFF));
        directed_scans.push_back(free_row(16'd361, 16'd0));
        // step equal to threshold ends a rise
        directed_scans.push_back(free_row(16'd378, 16'h8000));
        directed_scans.push_back(free_row(16'd394, 16'd0));
        // full-range swing of the diode
        directed_scans.push_back(free_row(16'h8000, 16'd14747));
        directed_scans.push_back(free_row(16'h7FFF, 16'd14747));
        directed_scans.push_back(free_row(16'h8000, 16'd0));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        idle_mode = IDLE_NONE;
        foreach (directed_scans[i]) begin
            send_scan(directed_scans[i].diode, directed_scans[i].camera,
                      directed_scans[i].pinned, directed_scans[i].want);
        end
        drain_results();

        run_phase(IDLE_NONE, 120, 1'b0);
        // top extremes: nothing can cross
        write_settings('1, '1, '1);
        run_phase(IDLE_SENDER, 100, 1'b0);
        // bottom extremes, plus a write to the spare slot
        write_settings('0, '0, '0);
        write_reg(REG_SPARE, $urandom);
        run_phase(IDLE_RECEIVER, 130, 1'b0);
        write_settings(LEVEL_W'($urandom_range(0, 32767)), STEP_W'($urandom_range(0, 80)),
                       MINH_W'($urandom_range(0, 400)));
        run_phase(IDLE_BOTH, 150, 1'b0);
        write_settings(LEVEL_W'($urandom_range(0, 32767)), STEP_W'($urandom_range(0, 40)),
                       MINH_W'($urandom_range(0, 200)));
        run_phase(IDLE_NONE, 100, 1'b1);
        write_settings(CAMERA_LEVEL_RST, RISE_STEP_RST, MIN_HEIGHT_RST);
        run_phase(IDLE_SENDER, 60, 1'b0);
        run_phase(IDLE_RECEIVER, 60, 1'b0);
        run_phase(IDLE_BOTH, 80, 1'b0);

        drain_results();
        repeat (10) @(posedge aclk);
        $display("scans %0d, camera rises %0d, diode pulses %0d, register writes %0d",
                 scans_sent, camera_edges_seen, pulses_seen, reg_writes);
        $display("settings from zero to full scale, with and without stalls on both sides");
        if (mismatches == 0 && scan_results_due.size() == 0) begin
            $display("tb_exposure_and_diode_edge_detector OK");
        end else begin
            $display("tb_exposure_and_diode_edge_detector NOT OK");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/eded_pkg.sv
hw/rtl/eded_regs.sv
hw/rtl/eded_camera.sv
hw/rtl/eded_diode.sv
hw/rtl/exposure_and_diode_edge_detector.sv
bench/tb_exposure_and_diode_edge_detector.sv
